@@ rtl/core/audio_three_band_level_meter_defines.svh @@
// ----------------------------------------------------------------------------
// audio three band level meter assertion macros
// property wrappers shared by the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef AUDIO_THREE_BAND_LEVEL_METER_DEFINES_SVH
`define AUDIO_THREE_BAND_LEVEL_METER_DEFINES_SVH

// same-cycle implication
`define ATBLM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATBLM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/atblm_pkg.sv @@
// ----------------------------------------------------------------------------
// atblm_pkg
// types, constants, microcode rom and helpers of the three band level meter
// ----------------------------------------------------------------------------
package atblm_pkg;

    // parameter defaults
    localparam int MAX_CHUNK_DEF    = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed point: internal values are signed q3.20 in 24 bits
    localparam int FRAC         = 20;
    localparam int DATA_W       = 24;
    localparam int OPND_W       = DATA_W + 1;   // magnitude of the most negative value
    localparam int COEF_W       = 24;
    localparam int MUL_W        = OPND_W + COEF_W;
    localparam int PROD_W       = 26;           // rounded product, |p| < 2^25
    localparam int ACC_W        = PROD_W + 1;
    localparam int MAG_W        = FRAC + 1;     // peak and band values, 0 .. 2^20
    localparam int SAMPLE_POINT = FRAC + 1;     // sample msb lands on bit 20
    localparam int ROUND_HALF   = 1 << (FRAC - 1);

    // configuration
    localparam int              CFG_W     = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd512;

    // output conversion q3.20 -> q1.15
    localparam int OUT_SHIFT = FRAC - 15;
    localparam int OUT_ROUND = 1 << (OUT_SHIFT - 1);

    // result item layout
    localparam int SUM_W         = 17;
    localparam int LEVEL_W       = 16;
    localparam int LOW_SUM_LSB   = 0;
    localparam int MID_SUM_LSB   = LOW_SUM_LSB + SUM_W;
    localparam int HIGH_BAND_LSB = MID_SUM_LSB + SUM_W;
    localparam int LOW_LVL_LSB   = HIGH_BAND_LSB + LEVEL_W;
    localparam int MID_LVL_LSB   = LOW_LVL_LSB + LEVEL_W;
    localparam int HIGH_LVL_LSB  = MID_LVL_LSB + LEVEL_W;
    localparam int OUT_FIELDS_W  = HIGH_LVL_LSB + LEVEL_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE    = 16'd32768;
    localparam logic [SUM_W-1:0]   BAND_SUM_MAX = 17'd65536;
    localparam logic signed [DATA_W-1:0] HALF_ONE = 24'sd524288;

    // coefficients, q.20
    localparam logic signed [COEF_W-1:0] K_098 = 24'sd1027604;
    localparam logic signed [COEF_W-1:0] K_002 = 24'sd20972;
    localparam logic signed [COEF_W-1:0] K_065 = 24'sd681574;
    localparam logic signed [COEF_W-1:0] K_396 = 24'sd4152361;
    localparam logic signed [COEF_W-1:0] K_070 = 24'sd734003;
    localparam logic signed [COEF_W-1:0] K_030 = 24'sd314573;
    localparam logic signed [COEF_W-1:0] K_090 = 24'sd943718;
    localparam logic signed [COEF_W-1:0] K_010 = 24'sd104858;
    localparam logic signed [COEF_W-1:0] K_080 = 24'sd838861;
    localparam logic signed [COEF_W-1:0] K_020 = 24'sd209715;
    localparam logic signed [COEF_W-1:0] K_150 = 24'sd1572864;
    localparam logic signed [COEF_W-1:0] K_200 = 24'sd2097152;

    // microcode fields
    typedef enum logic [3:0] {
        SRC_NONE, SRC_X, SRC_LP, SRC_HP, SRC_LE, SRC_HE, SRC_ACC_SAT, SRC_ACC_MAG,
        SRC_SL, SRC_SM, SRC_SH, SRC_VLOW, SRC_VMID, SRC_VHIGH
    } t_src;

    typedef enum logic [3:0] {
        C_098, C_002, C_065, C_396, C_070, C_030, C_090, C_010, C_080, C_020,
        C_150, C_200
    } t_coef;

    typedef enum logic [2:0] {
        AOP_HOLD, AOP_LOAD, AOP_ADD, AOP_XSUB, AOP_SUB_HP
    } t_aop;

    typedef enum logic [3:0] {
        DST_NONE, DST_LP, DST_LE, DST_HP, DST_HE, DST_VHIGH, DST_VLOW, DST_VMID,
        DST_SL, DST_SM, DST_SH
    } t_dst;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_WAIT_IN, SEQ_END_SAMPLE, SEQ_EMIT
    } t_seq;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] PC_FIRST = 5'd1;
    localparam logic [PC_W-1:0] PC_CHUNK = 5'd13;

    typedef struct packed {
        t_src            src;
        t_coef           coef;
        t_aop            aop;
        t_dst            dst;
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic logic signed [COEF_W-1:0] coef_value(input t_coef c);
        logic signed [COEF_W-1:0] k;
        unique case (c)
            C_098:   k = K_098;
            C_002:   k = K_002;
            C_065:   k = K_065;
            C_396:   k = K_396;
            C_070:   k = K_070;
            C_030:   k = K_030;
            C_090:   k = K_090;
            C_010:   k = K_010;
            C_080:   k = K_080;
            C_020:   k = K_020;
            C_150:   k = K_150;
            C_200:   k = K_200;
            default: k = '0;
        endcase
        return k;
    endfunction

    // program: products issue one step ahead of the accumulator op that uses them
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w.src    = SRC_NONE;
        w.coef   = C_098;
        w.aop    = AOP_HOLD;
        w.dst    = DST_NONE;
        w.seq    = SEQ_NEXT;
        w.target = PC_WAIT;
        unique case (pc)
            // wait for a sample
            5'd0: begin w.seq = SEQ_WAIT_IN; w.target = PC_FIRST; end
            // low-pass and its envelope
            5'd1: begin w.src = SRC_LP; w.coef = C_098; end
            5'd2: begin w.src = SRC_X; w.coef = C_002; w.aop = AOP_LOAD; end
            5'd3: begin w.src = SRC_LE; w.coef = C_098; w.aop = AOP_ADD; end
            5'd4: begin
                w.src = SRC_ACC_MAG; w.coef = C_002; w.aop = AOP_LOAD; w.dst = DST_LP;
            end
            5'd5: begin w.src = SRC_HP; w.coef = C_065; w.aop = AOP_ADD; end
            // high-pass and its envelope
            5'd6: begin w.aop = AOP_XSUB; w.dst = DST_LE; end
            5'd7: begin w.aop = AOP_SUB_HP; w.dst = DST_HP; end
            5'd8: begin w.src = SRC_ACC_SAT; w.coef = C_396; end
            5'd9: begin w.src = SRC_HE; w.coef = C_070; w.aop = AOP_LOAD; end
            5'd10: begin w.src = SRC_ACC_MAG; w.coef = C_030; w.aop = AOP_LOAD; end
            5'd11: begin w.aop = AOP_ADD; end
            5'd12: begin w.dst = DST_HE; w.seq = SEQ_END_SAMPLE; w.target = PC_CHUNK; end
            // chunk end: band values
            5'd13: begin w.src = SRC_HE; w.coef = C_150; end
            5'd14: begin w.src = SRC_LE; w.coef = C_200; w.aop = AOP_LOAD; end
            5'd15: begin w.aop = AOP_LOAD; w.dst = DST_VHIGH; end
            5'd16: begin w.src = SRC_SL; w.coef = C_090; w.dst = DST_VLOW; end
            // smoothed levels
            5'd17: begin
                w.src = SRC_VLOW; w.coef = C_010; w.aop = AOP_LOAD; w.dst = DST_VMID;
            end
            5'd18: begin w.src = SRC_SM; w.coef = C_080; w.aop = AOP_ADD; end
            5'd19: begin
                w.src = SRC_VMID; w.coef = C_020; w.aop = AOP_LOAD; w.dst = DST_SL;
            end
            5'd20: begin w.src = SRC_SH; w.coef = C_070; w.aop = AOP_ADD; end
            5'd21: begin
                w.src = SRC_VHIGH; w.coef = C_030; w.aop = AOP_LOAD; w.dst = DST_SM;
            end
            5'd22: begin w.aop = AOP_ADD; end
            5'd23: begin w.dst = DST_SH; end
            5'd24: begin w.seq = SEQ_EMIT; w.target = PC_WAIT; end
            default: begin w.seq = SEQ_NEXT; w.target = PC_WAIT; end
        endcase
        return w;
    endfunction

    // saturate the accumulator to the 24-bit state range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] a);
        logic signed [DATA_W-1:0] s;
        priority if (a[ACC_W-1:DATA_W-1] == '0 || a[ACC_W-1:DATA_W-1] == '1) begin
            s = a[DATA_W-1:0];
        end else if (a[ACC_W-1]) begin
            s = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            s = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s;
    endfunction

    // smoothed level doubled, limited to 1.0, rounded to q1.15
    function automatic logic [LEVEL_W-1:0] level_q15(input logic signed [DATA_W-1:0] q);
        logic [FRAC:0]   d;
        logic [FRAC+1:0] r;
        logic [LEVEL_W-1:0] res;
        d = {q[FRAC-1:0], 1'b0};
        r = ({1'b0, d} + (FRAC+2)'(OUT_ROUND)) >> OUT_SHIFT;
        priority if (q <= 0) begin
            res = '0;
        end else if (q > HALF_ONE) begin
            res = LEVEL_ONE;
        end else begin
            res = r[LEVEL_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/audio_three_band_level_meter.sv @@
// ----------------------------------------------------------------------------
// audio three band level meter
// Takes one signed sample per input item, runs a one-pole low-pass and a
// first-order high-pass on it, follows each with a rectified envelope and
// tracks the peak of the absolute sample. Every chunk_length samples (zero
// counts as one, values above MAX_CHUNK as MAX_CHUNK) one result item comes
// out: the high band level, the mid+high and low+mid+high band sums, and three
// smoothed levels doubled and limited to 1.0; levels q1.15, sums q2.15, both
// with 32768 as 1.0. Filter and smoothing math uses a single 25x24 signed
// multiplier and one adder stepped by a 25-word microcode rom. A sample takes
// the accept step plus 12 rom steps; the last sample of a chunk adds 12 steps
// for the band and smoothing math, and the emit step waits while the previous
// result item still sits in the output register. chunk_length is written via
// i_cfg_we/i_cfg_wdata by the user while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module audio_three_band_level_meter #(
    parameter int MAX_CHUNK    = atblm_pkg::MAX_CHUNK_DEF,
    parameter int SAMPLE_WIDTH = atblm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration: chunk_length
    input  logic                                  i_cfg_we,
    input  logic [atblm_pkg::CFG_W-1:0]           i_cfg_wdata,
    // sample items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample, rest zero
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // low_band_sum, mid_band_sum, high_band, low_level, mid_level, high_level
    // from bit 0 up, zero padded
    output logic [atblm_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int DATA_W = atblm_pkg::DATA_W;
    localparam int MAG_W  = atblm_pkg::MAG_W;
    localparam int ACC_W  = atblm_pkg::ACC_W;
    localparam int PROD_W = atblm_pkg::PROD_W;
    localparam int OPND_W = atblm_pkg::OPND_W;
    localparam int MUL_W  = atblm_pkg::MUL_W;
    localparam int SUM_W  = atblm_pkg::SUM_W;
    localparam int LVL_W  = atblm_pkg::LEVEL_W;
    localparam int CFG_W  = atblm_pkg::CFG_W;
    localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
    localparam int LEN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BSUM_W = MAG_W + 2;

    // sequencer and control
    logic [atblm_pkg::PC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CFG_W-1:0]           r_chunk_len, n_chunk_len;
    logic                       r_out_valid, n_out_valid;

    // persistent and per-chunk state
    logic signed [DATA_W-1:0] r_lp, n_lp, r_hp, n_hp;
    logic signed [DATA_W-1:0] r_le, n_le, r_he, n_he;
    logic signed [DATA_W-1:0] r_sl, n_sl, r_sm, n_sm, r_sh, n_sh;
    logic [MAG_W-1:0]         r_peak, n_peak;

    // datapath payload
    logic signed [DATA_W-1:0]  r_x, n_x;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [MAG_W-1:0]          r_vlow, n_vlow, r_vmid, n_vmid, r_vhigh, n_vhigh;
    logic [atblm_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    atblm_pkg::t_uword w_uw;

    logic signed [DATA_W-1:0] w_x_in, w_x_neg, w_acc_sat;
    logic [MAG_W-1:0]         w_x_mag, w_clip;
    logic signed [OPND_W-1:0] w_acc_wide, w_acc_mag, w_opnd;
    logic signed [atblm_pkg::COEF_W-1:0] w_coef;
    logic signed [MUL_W-1:0]  w_mul, w_mul_rnd, w_mul_shift;
    logic signed [BSUM_W-1:0] w_mid_diff;
    logic [BSUM_W-1:0]        w_sum, w_sum_q, w_mh_sum, w_mh_q;
    logic [MAG_W:0]           w_hb_q;
    logic [SUM_W-1:0]         w_low_sum, w_mid_sum;
    logic [LVL_W-1:0]         w_high_band;
    logic [LEN_W-1:0]         w_len, w_cfg_len;
    logic [CNT_W-1:0]         w_cnt_inc;
    logic                     w_chunk_done, w_in_fire, w_out_free;

    // sample to q3.20
    generate
        if (SAMPLE_WIDTH <= atblm_pkg::SAMPLE_POINT) begin : g_scale_up
            assign w_x_in = DATA_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]))
                            <<< (atblm_pkg::SAMPLE_POINT - SAMPLE_WIDTH);
        end else begin : g_scale_down
            assign w_x_in = DATA_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])
                            >>> (SAMPLE_WIDTH - atblm_pkg::SAMPLE_POINT));
        end
    endgenerate

    assign w_x_neg = -w_x_in;
    assign w_x_mag = w_x_in[DATA_W-1] ? w_x_neg[MAG_W-1:0] : w_x_in[MAG_W-1:0];

    // current control word
    assign w_uw = atblm_pkg::ucode(r_pc);

    // handshakes: input taken only in the wait step, result register frees on take
    assign s_axis_tready = (w_uw.seq == atblm_pkg::SEQ_WAIT_IN);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // accumulator views
    assign w_acc_sat  = atblm_pkg::sat_data(r_acc);
    assign w_acc_wide = OPND_W'(w_acc_sat);
    assign w_acc_mag  = w_acc_sat[DATA_W-1] ? -w_acc_wide : w_acc_wide;

    // multiplier operand select
    always_comb begin
        unique case (w_uw.src)
            atblm_pkg::SRC_X:       w_opnd = OPND_W'(r_x);
            atblm_pkg::SRC_LP:      w_opnd = OPND_W'(r_lp);
            atblm_pkg::SRC_HP:      w_opnd = OPND_W'(r_hp);
            atblm_pkg::SRC_LE:      w_opnd = OPND_W'(r_le);
            atblm_pkg::SRC_HE:      w_opnd = OPND_W'(r_he);
            atblm_pkg::SRC_ACC_SAT: w_opnd = w_acc_wide;
            atblm_pkg::SRC_ACC_MAG: w_opnd = w_acc_mag;
            atblm_pkg::SRC_SL:      w_opnd = OPND_W'(r_sl);
            atblm_pkg::SRC_SM:      w_opnd = OPND_W'(r_sm);
            atblm_pkg::SRC_SH:      w_opnd = OPND_W'(r_sh);
            atblm_pkg::SRC_VLOW:    w_opnd = $signed(OPND_W'(r_vlow));
            atblm_pkg::SRC_VMID:    w_opnd = $signed(OPND_W'(r_vmid));
            atblm_pkg::SRC_VHIGH:   w_opnd = $signed(OPND_W'(r_vhigh));
            default:                w_opnd = '0;
        endcase
    end

    // shared multiplier, round half up, floor shift back to q3.20
    assign w_coef      = atblm_pkg::coef_value(w_uw.coef);
    assign w_mul       = MUL_W'(w_opnd) * MUL_W'(w_coef);
    assign w_mul_rnd   = w_mul + MUL_W'(atblm_pkg::ROUND_HALF);
    assign w_mul_shift = w_mul_rnd >>> atblm_pkg::FRAC;

    // band value limited to the chunk peak
    assign w_clip = (w_acc_sat > $signed(DATA_W'(r_peak))) ? r_peak : w_acc_sat[MAG_W-1:0];

    // mid band: peak minus low and high, floored at zero
    assign w_mid_diff = $signed(BSUM_W'(r_peak)) - $signed(BSUM_W'(r_vlow))
                      - $signed(BSUM_W'(r_vhigh));

    // chunk length clamp and sample counter
    assign w_cfg_len = LEN_W'(r_chunk_len);
    always_comb begin
        priority if (r_chunk_len == '0) begin
            w_len = LEN_W'(1);
        end else if (w_cfg_len > LEN_W'(MAX_CHUNK)) begin
            w_len = LEN_W'(MAX_CHUNK);
        end else begin
            w_len = w_cfg_len;
        end
    end
    assign w_cnt_inc    = r_count + CNT_W'(1);
    assign w_chunk_done = LEN_W'(w_cnt_inc) >= w_len;

    // result conversion to q1.15
    assign w_sum    = BSUM_W'(r_vlow) + BSUM_W'(r_vmid) + BSUM_W'(r_vhigh);
    assign w_sum_q  = (w_sum + BSUM_W'(atblm_pkg::OUT_ROUND)) >> atblm_pkg::OUT_SHIFT;
    assign w_mh_sum = BSUM_W'(r_vmid) + BSUM_W'(r_vhigh);
    assign w_mh_q   = (w_mh_sum + BSUM_W'(atblm_pkg::OUT_ROUND)) >> atblm_pkg::OUT_SHIFT;
    assign w_hb_q   = ({1'b0, r_vhigh} + (MAG_W+1)'(atblm_pkg::OUT_ROUND))
                      >> atblm_pkg::OUT_SHIFT;

    assign w_low_sum = (w_sum_q > BSUM_W'(atblm_pkg::BAND_SUM_MAX)) ?
                       atblm_pkg::BAND_SUM_MAX : w_sum_q[SUM_W-1:0];
    assign w_mid_sum = (w_mh_q > BSUM_W'(atblm_pkg::BAND_SUM_MAX)) ?
                       atblm_pkg::BAND_SUM_MAX : w_mh_q[SUM_W-1:0];
    assign w_high_band = (w_hb_q > (MAG_W+1)'(atblm_pkg::LEVEL_ONE)) ?
                         atblm_pkg::LEVEL_ONE : w_hb_q[LVL_W-1:0];

    // next state: datapath writes from the control word, then sequencing
    always_comb begin
        n_pc        = r_pc;
        n_count     = r_count;
        n_chunk_len = i_cfg_we ? i_cfg_wdata : r_chunk_len;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_lp        = r_lp;
        n_hp        = r_hp;
        n_le        = r_le;
        n_he        = r_he;
        n_sl        = r_sl;
        n_sm        = r_sm;
        n_sh        = r_sh;
        n_peak      = r_peak;
        n_x         = r_x;
        n_vlow      = r_vlow;
        n_vmid      = r_vmid;
        n_vhigh     = r_vhigh;

        // product register only loads on a multiply step
        n_prod = (w_uw.src != atblm_pkg::SRC_NONE) ? w_mul_shift[PROD_W-1:0] : r_prod;

        unique case (w_uw.aop)
            atblm_pkg::AOP_HOLD:   n_acc = r_acc;
            atblm_pkg::AOP_LOAD:   n_acc = ACC_W'(r_prod);
            atblm_pkg::AOP_ADD:    n_acc = r_acc + ACC_W'(r_prod);
            atblm_pkg::AOP_XSUB:   n_acc = ACC_W'(r_x) - ACC_W'(r_prod);
            atblm_pkg::AOP_SUB_HP: n_acc = r_acc - ACC_W'(r_hp);
            default:               n_acc = r_acc;
        endcase

        unique case (w_uw.dst)
            atblm_pkg::DST_NONE:  ;
            atblm_pkg::DST_LP:    n_lp = w_acc_sat;
            atblm_pkg::DST_LE:    n_le = w_acc_sat;
            atblm_pkg::DST_HP:    n_hp = w_acc_sat;
            atblm_pkg::DST_HE:    n_he = w_acc_sat;
            atblm_pkg::DST_VHIGH: n_vhigh = w_clip;
            atblm_pkg::DST_VLOW:  n_vlow = w_clip;
            atblm_pkg::DST_VMID:  n_vmid = w_mid_diff[BSUM_W-1] ? '0 : w_mid_diff[MAG_W-1:0];
            atblm_pkg::DST_SL:    n_sl = w_acc_sat;
            atblm_pkg::DST_SM:    n_sm = w_acc_sat;
            atblm_pkg::DST_SH:    n_sh = w_acc_sat;
            default:              ;
        endcase

        unique case (w_uw.seq)
            atblm_pkg::SEQ_NEXT: begin
                n_pc = r_pc + atblm_pkg::PC_W'(1);
            end
            atblm_pkg::SEQ_WAIT_IN: begin
                // take a sample, latch it and update the peak
                if (w_in_fire) begin
                    n_pc = w_uw.target;
                    n_x  = w_x_in;
                    if (w_x_mag > r_peak) begin
                        n_peak = w_x_mag;
                    end
                end
            end
            atblm_pkg::SEQ_END_SAMPLE: begin
                // chunk done: branch to the band math, else back to wait
                if (w_chunk_done) begin
                    n_pc    = w_uw.target;
                    n_count = '0;
                end else begin
                    n_pc    = atblm_pkg::PC_WAIT;
                    n_count = w_cnt_inc;
                end
            end
            atblm_pkg::SEQ_EMIT: begin
                // hold until the output register is free, then restart the chunk
                if (w_out_free) begin
                    n_pc        = w_uw.target;
                    n_out_valid = 1'b1;
                    n_out_data  = {{atblm_pkg::OUT_PAD_W{1'b0}},
                                   atblm_pkg::level_q15(r_sh),
                                   atblm_pkg::level_q15(r_sm),
                                   atblm_pkg::level_q15(r_sl),
                                   w_high_band, w_mid_sum, w_low_sum};
                    n_le        = '0;
                    n_he        = '0;
                    n_peak      = '0;
                end
            end
            default: begin
                n_pc = atblm_pkg::PC_WAIT;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= atblm_pkg::PC_WAIT;
            r_count     <= '0;
            r_chunk_len <= atblm_pkg::CFG_RESET;
            r_out_valid <= 1'b0;
            r_lp        <= '0;
            r_hp        <= '0;
            r_le        <= '0;
            r_he        <= '0;
            r_sl        <= '0;
            r_sm        <= '0;
            r_sh        <= '0;
            r_peak      <= '0;
        end else begin
            r_pc        <= n_pc;
            r_count     <= n_count;
            r_chunk_len <= n_chunk_len;
            r_out_valid <= n_out_valid;
            r_lp        <= n_lp;
            r_hp        <= n_hp;
            r_le        <= n_le;
            r_he        <= n_he;
            r_sl        <= n_sl;
            r_sm        <= n_sm;
            r_sh        <= n_sh;
            r_peak      <= n_peak;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_vlow     <= n_vlow;
        r_vmid     <= n_vmid;
        r_vhigh    <= n_vhigh;
        r_out_data <= n_out_data;
    end

endmodule

@@ rtl/core/atblm_checker.sv @@
// ----------------------------------------------------------------------------
// atblm_checker
// port-level checks of the three band level meter, bound to the top level
// ----------------------------------------------------------------------------
`include "audio_three_band_level_meter_defines.svh"

module atblm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [atblm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [atblm_pkg::SUM_W-1:0]   w_low_sum, w_mid_sum;
    logic [atblm_pkg::LEVEL_W-1:0] w_high_band, w_low_lvl, w_mid_lvl, w_high_lvl;
    logic                          w_levels_ok, w_order_ok;

    assign w_low_sum   = m_axis_tdata[atblm_pkg::LOW_SUM_LSB +: atblm_pkg::SUM_W];
    assign w_mid_sum   = m_axis_tdata[atblm_pkg::MID_SUM_LSB +: atblm_pkg::SUM_W];
    assign w_high_band = m_axis_tdata[atblm_pkg::HIGH_BAND_LSB +: atblm_pkg::LEVEL_W];
    assign w_low_lvl   = m_axis_tdata[atblm_pkg::LOW_LVL_LSB +: atblm_pkg::LEVEL_W];
    assign w_mid_lvl   = m_axis_tdata[atblm_pkg::MID_LVL_LSB +: atblm_pkg::LEVEL_W];
    assign w_high_lvl  = m_axis_tdata[atblm_pkg::HIGH_LVL_LSB +: atblm_pkg::LEVEL_W];

    // levels and high band never pass 1.0
    assign w_levels_ok = (w_high_band <= atblm_pkg::LEVEL_ONE)
                      && (w_low_lvl <= atblm_pkg::LEVEL_ONE)
                      && (w_mid_lvl <= atblm_pkg::LEVEL_ONE)
                      && (w_high_lvl <= atblm_pkg::LEVEL_ONE);

    // band sums nest: high <= mid+high <= low+mid+high
    assign w_order_ok = (atblm_pkg::SUM_W'(w_high_band) <= w_mid_sum)
                     && (w_mid_sum <= w_low_sum);

    `ATBLM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
    `ATBLM_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sample taken while previous one still in work")
    `ATBLM_ASSERT_IMP(a_level_range, m_axis_tvalid, w_levels_ok, "level above full scale")
    `ATBLM_ASSERT_IMP(a_band_order, m_axis_tvalid, w_order_ok, "band sums out of order")

endmodule

bind audio_three_band_level_meter atblm_checker u_atblm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
